### rtl/trial_division_primality_test_macros.svh
// assertion macros of the primality test rtl
`ifndef TRIAL_DIVISION_PRIMALITY_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIMALITY_TEST_MACROS_SVH

// same-cycle implication, checked out of reset
`define TDPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdpt assertion failed");

// next-cycle implication, checked out of reset
`define TDPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdpt assertion failed");

`endif

### rtl/tdpt_pkg.sv
// shared constants and types of the primality test
`default_nettype none

package tdpt_pkg;

    // width of the signed input value
    localparam int VALUE_WIDTH = 32;
    // magnitude bits of a non-negative value
    localparam int MAG_W = VALUE_WIDTH - 1;
    // iteration counter of the serial divider
    localparam int CNT_W = $clog2(MAG_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);

    // first trial divisor and divisor step
    localparam logic [MAG_W-1:0] FIRST_DIVISOR = MAG_W'(3);
    localparam logic [MAG_W-1:0] DIVISOR_STEP = MAG_W'(2);
    localparam logic [MAG_W-1:0] SMALLEST_PRIME = MAG_W'(2);

    // request to the serial divider
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [MAG_W-1:0] divisor;
    } tdpt_div_req_t;

    // response from the serial divider
    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
        logic             rem_zero;
    } tdpt_div_rsp_t;

endpackage

`default_nettype wire

### rtl/tdpt_serdiv.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module tdpt_serdiv
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire tdpt_pkg::tdpt_div_req_t req,
    output tdpt_pkg::tdpt_div_rsp_t      rsp
);

    logic                        active_reg, active_next;
    logic                        done_reg, done_next;
    logic [tdpt_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [tdpt_pkg::MAG_W-1:0]  work_reg, work_next;
    logic [tdpt_pkg::MAG_W-1:0]  rem_reg, rem_next;
    logic [tdpt_pkg::MAG_W-1:0]  divisor_reg, divisor_next;
    logic [tdpt_pkg::MAG_W:0]    shifted;
    logic [tdpt_pkg::MAG_W:0]    diff;
    logic                        fits;

    // one restoring step: bring down the next dividend bit
    always_comb
    begin
        shifted = {rem_reg, work_reg[tdpt_pkg::MAG_W-1]};
        diff    = shifted - {1'b0, divisor_reg};
        fits    = shifted >= {1'b0, divisor_reg};
    end

    // load on start, then iterate over the dividend bits
    always_comb
    begin
        active_next  = active_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            active_next  = 1'b1;
            cnt_next     = tdpt_pkg::CNT_LAST;
            work_next    = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
        end
        else if (active_reg)
        begin
            work_next = {work_reg[tdpt_pkg::MAG_W-2:0], fits};
            rem_next  = fits ? diff[tdpt_pkg::MAG_W-1:0] : shifted[tdpt_pkg::MAG_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    // quotient and remainder are final when done is high
    always_comb
    begin
        rsp.done     = done_reg;
        rsp.quotient = work_reg;
        rsp.rem_zero = rem_reg == '0;
    end

endmodule

`default_nettype wire

### rtl/trial_division_primality_test.sv
// primality test of a signed value by trial division with odd divisors
// values below 3 and even values are answered without the divider; an odd value is tested
// against k odd divisors in turn, where k is up to about 23170
// each divisor is loaded into the bit-serial divider, which then steps through the 31 dividend bits
// throughput: one item at a time, start is taken only while busy is low
// reset clears the sequencer and the done strobe; the result is not held off by the receiver
`default_nettype none

module trial_division_primality_test
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic signed [tdpt_pkg::VALUE_WIDTH-1:0] value,
    output logic                                  done,
    output logic                                  is_prime
);

    `include "trial_division_primality_test_macros.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                        state_reg, state_next;
    logic                        done_reg, done_next;
    logic                        is_prime_reg, is_prime_next;
    logic [tdpt_pkg::MAG_W-1:0]  value_reg, value_next;
    logic [tdpt_pkg::MAG_W-1:0]  d_reg, d_next;
    logic [tdpt_pkg::MAG_W-1:0]  mag;
    logic                        accept;
    tdpt_pkg::tdpt_div_req_t     div_req;
    tdpt_pkg::tdpt_div_rsp_t     div_rsp;

    assign mag    = value[tdpt_pkg::MAG_W-1:0];
    assign accept = start && (state_reg == ST_IDLE);

    // sequencer over the odd trial divisors
    always_comb
    begin
        state_next       = state_reg;
        done_next        = 1'b0;
        is_prime_next    = is_prime_reg;
        value_next       = value_reg;
        d_next           = d_reg;
        div_req.start    = 1'b0;
        div_req.dividend = value_reg;
        div_req.divisor  = d_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    value_next = mag;
                    if (value[tdpt_pkg::VALUE_WIDTH-1] || (mag < tdpt_pkg::SMALLEST_PRIME))
                    begin
                        done_next     = 1'b1;
                        is_prime_next = 1'b0;
                    end
                    else if (mag == tdpt_pkg::SMALLEST_PRIME)
                    begin
                        done_next     = 1'b1;
                        is_prime_next = 1'b1;
                    end
                    else if (!mag[0])
                    begin
                        done_next     = 1'b1;
                        is_prime_next = 1'b0;
                    end
                    else
                    begin
                        d_next           = tdpt_pkg::FIRST_DIVISOR;
                        div_req.start    = 1'b1;
                        div_req.dividend = mag;
                        div_req.divisor  = tdpt_pkg::FIRST_DIVISOR;
                        state_next       = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (div_rsp.done)
                begin
                    // divisor past the square root bound: no factor found
                    if (d_reg > div_rsp.quotient)
                    begin
                        done_next     = 1'b1;
                        is_prime_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else if (div_rsp.rem_zero)
                    begin
                        done_next     = 1'b1;
                        is_prime_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        d_next          = d_reg + tdpt_pkg::DIVISOR_STEP;
                        div_req.start   = 1'b1;
                        div_req.divisor = d_next;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        is_prime_reg <= is_prime_next;
        value_reg    <= value_next;
        d_reg        <= d_next;
    end

    // serial divider
    tdpt_serdiv u_serdiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // outputs
    assign busy     = state_reg == ST_RUN;
    assign done     = done_reg;
    assign is_prime = is_prime_reg;

    // checks
    `TDPT_ASSERT_NOW(a_done_when_idle, clk, rst_n, done_reg, state_reg == ST_IDLE)
    `TDPT_ASSERT_NOW(a_div_done_in_run, clk, rst_n, div_rsp.done, state_reg == ST_RUN)
    `TDPT_ASSERT_NOW(a_divisor_odd, clk, rst_n, state_reg == ST_RUN, d_reg[0])
    `TDPT_ASSERT_NEXT(a_divisor_holds, clk, rst_n, (state_reg == ST_RUN) && !div_rsp.done,
                      $stable(d_reg))

endmodule

`default_nettype wire

### tb/tb_trial_division_primality_test.sv
// self-checking testbench of the trial division primality test
`timescale 1ns / 1ps

module tb_trial_division_primality_test;

    localparam int VW = tdpt_pkg::VALUE_WIDTH;
    // cost cap for random odd values, in trial divisors
    localparam int unsigned MAX_RANDOM_TRIALS = 256;
    localparam int unsigned RANDOM_ITEMS = 100;
    localparam int unsigned TAIL_CYCLES = 100;

    // one item waiting to be sent
    typedef struct {
        logic signed [VW-1:0] value;
        int unsigned          idle_pct;
        bit                   drain_first;
    } value_item_t;

    // one answer waiting to come back
    typedef struct {
        logic signed [VW-1:0] value;
        logic                 is_prime;
    } prime_answer_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic signed [VW-1:0] value = '0;
    logic                 busy;
    logic                 done;
    logic                 is_prime;

    value_item_t   value_queue[$];
    prime_answer_t prime_answer_q[$];
    bit            item_taken = 1'b0;
    logic          next_start;
    int unsigned   error_count = 0;
    int unsigned   result_count = 0;

    trial_division_primality_test u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .value    (value),
        .done     (done),
        .is_prime (is_prime)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // primality by odd trial divisors, also counts the divisors tried
    function automatic logic prime_of(input logic signed [VW-1:0] v,
                                      output int unsigned trials);
        logic [VW-1:0] mag;
        logic [VW-1:0] d;
        trials = 0;
        mag = v;
        // negative values and values below two
        if (v[VW-1] || mag < 2)
            return 1'b0;
        if (mag == 2)
            return 1'b1;
        if (!mag[0])
            return 1'b0;
        // divisor bound without forming the product
        for (d = 3; d <= mag / d; d += 2)
        begin
            trials++;
            if (mag % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic queue_value(input logic signed [VW-1:0] v, input int unsigned idle_pct,
                               input bit drain_first);
        value_item_t it;
        it.value = v;
        it.idle_pct = idle_pct;
        it.drain_first = drain_first;
        value_queue.push_back(it);
    endtask

    // driver: presents the next item at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!start || item_taken))
        begin
            next_start = 1'b0;
            if (value_queue.size() > 0)
            begin
                // hold off until every answer is back
                if (value_queue[0].drain_first && prime_answer_q.size() != 0)
                    next_start = 1'b0;
                else if ($urandom_range(1, 100) > value_queue[0].idle_pct)
                begin
                    next_start = 1'b1;
                    value <= value_queue[0].value;
                    void'(value_queue.pop_front());
                end
            end
            start <= next_start;
            item_taken = 1'b0;
        end
    end

    // monitor: checks results and records accepted items
    always @(posedge clk)
    begin
        prime_answer_t exp_ans;
        int unsigned   trials;
        if (rst_n)
        begin
            // result check
            if (done)
            begin
                if (prime_answer_q.size() == 0)
                begin
                    $display("%0t: result with no item waiting, expected none, actual is_prime %0b",
                             $time, is_prime);
                    error_count++;
                end
                else
                begin
                    exp_ans = prime_answer_q.pop_front();
                    result_count++;
                    if (is_prime !== exp_ans.is_prime)
                    begin
                        $display("%0t: value %0d is_prime expected %0b actual %0b",
                                 $time, exp_ans.value, exp_ans.is_prime, is_prime);
                        error_count++;
                    end
                end
            end
            // item accepted
            if (start && !busy)
            begin
                exp_ans.value = value;
                exp_ans.is_prime = prime_of(value, trials);
                prime_answer_q.push_back(exp_ans);
                item_taken = 1'b1;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        logic signed [VW-1:0] v;
        int unsigned          kind;
        int unsigned          trials;
        int unsigned          idle_pct;
        int unsigned          total_items;

        // directed values: zero, one, two, small primes and squares, negatives, extremes
        queue_value(0, 35, 1'b0);
        queue_value(1, 35, 1'b0);
        queue_value(2, 35, 1'b0);
        queue_value(3, 35, 1'b0);
        queue_value(4, 35, 1'b0);
        queue_value(5, 35, 1'b0);
        queue_value(6, 35, 1'b0);
        queue_value(9, 35, 1'b0);
        queue_value(15, 35, 1'b0);
        queue_value(25, 35, 1'b0);
        queue_value(49, 35, 1'b0);
        queue_value(97, 35, 1'b0);
        queue_value(121, 35, 1'b0);
        queue_value(169, 35, 1'b0);
        queue_value(-1, 35, 1'b0);
        queue_value(-7, 35, 1'b0);
        queue_value({1'b1, {(VW-1){1'b0}}}, 35, 1'b0);
        queue_value({1'b0, {(VW-2){1'b1}}, 1'b0}, 35, 1'b0);
        queue_value({1'b0, {(VW-3){1'b1}}, 2'b01}, 35, 1'b0);
        // largest value is prime and walks the full divisor range
        queue_value({1'b0, {(VW-1){1'b1}}}, 35, 1'b1);

        // random values, mostly cheap, large odd ones kept to few divisors
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_pct = (i < RANDOM_ITEMS / 3) ? 35 : (i < 2 * RANDOM_ITEMS / 3) ? 75 : 0;
            kind = $urandom_range(0, 9);
            if (kind < 2)
            begin
                v = $urandom();
                v[VW-1] = 1'b1;
            end
            else if (kind < 6)
            begin
                v = $urandom_range(0, 16383);
                if ($urandom_range(0, 1))
                    v[0] = 1'b1;
            end
            else
            begin
                v = $urandom();
                v[VW-1] = 1'b0;
                if ($urandom_range(0, 1))
                    v[0] = 1'b1;
                void'(prime_of(v, trials));
                if (trials > MAX_RANDOM_TRIALS)
                    v = v - (v % 3);
            end
            queue_value(v, idle_pct, i == 0 || i == RANDOM_ITEMS / 2);
        end
        total_items = value_queue.size();

        // reset
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait until every item has been answered and checked
        @(negedge clk);
        while (result_count < total_items)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #100_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/tdpt_pkg.sv
rtl/tdpt_serdiv.sv
rtl/trial_division_primality_test.sv
tb/tb_trial_division_primality_test.sv
